// ===== src/ler_pkg.sv =====
// shared types, constants and step program of the lorenz euler integrator
package ler_pkg;

   localparam int WORD_W = 32;
   localparam int FRAC_W = 24;
   localparam int DT_W = WORD_W - 1;
   localparam int PROD_W = 2 * WORD_W;
   localparam int ADDR_W = 5;
   localparam int REG_IDX_W = 3;
   localparam int NUM_STEPS = 16;
   localparam int STEP_W = $clog2(NUM_STEPS);
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 104;

   localparam logic [WORD_W-1:0] WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
   localparam logic [WORD_W-1:0] WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};

   localparam logic [WORD_W-1:0] SIGMA_RST = 32'd167772160;
   localparam logic [WORD_W-1:0] BETA_RST = 32'd44738124;
   localparam logic [WORD_W-1:0] RHO_RST = 32'd469762048;
   localparam logic [DT_W-1:0] DT_RST = 31'd16777;
   localparam logic [WORD_W-1:0] START_RST = 32'd16777216;

   typedef enum logic [REG_IDX_W-1:0] {
      REG_SIGMA = 3'd0,
      REG_BETA = 3'd1,
      REG_RHO = 3'd2,
      REG_TIME_STEP = 3'd3,
      REG_START_X = 3'd4,
      REG_START_Y = 3'd5,
      REG_START_Z = 3'd6,
      REG_NONE = 3'd7
   } reg_idx_type;

   typedef enum logic [1:0] {
      OP_ADD,
      OP_SUB,
      OP_MUL
   } op_type;

   typedef enum logic [3:0] {
      SRC_X,
      SRC_Y,
      SRC_Z,
      SRC_SIGMA,
      SRC_BETA,
      SRC_RHO,
      SRC_DT,
      SRC_T0,
      SRC_T1,
      SRC_T2,
      SRC_PROD,
      SRC_ZERO
   } src_type;

   typedef enum logic [2:0] {
      DST_T0,
      DST_T1,
      DST_T2,
      DST_X,
      DST_Y,
      DST_Z
   } dst_type;

   typedef struct packed {
      op_type op;
      src_type src_a;
      src_type src_b;
      dst_type dst;
   } uop_type;

   // one euler step; a multiply leaves its product for the next step to consume
   function automatic uop_type uop_at(logic [STEP_W-1:0] step);
      uop_type u;
      unique case (step)
         4'd0:  u = '{OP_SUB, SRC_Y, SRC_X, DST_T0};
         4'd1:  u = '{OP_SUB, SRC_RHO, SRC_Z, DST_T1};
         4'd2:  u = '{OP_MUL, SRC_SIGMA, SRC_T0, DST_T0};
         4'd3:  u = '{OP_ADD, SRC_PROD, SRC_ZERO, DST_T0};
         4'd4:  u = '{OP_MUL, SRC_X, SRC_T1, DST_T1};
         4'd5:  u = '{OP_SUB, SRC_PROD, SRC_Y, DST_T1};
         4'd6:  u = '{OP_MUL, SRC_X, SRC_Y, DST_T2};
         4'd7:  u = '{OP_ADD, SRC_PROD, SRC_ZERO, DST_T2};
         4'd8:  u = '{OP_MUL, SRC_BETA, SRC_Z, DST_T2};
         4'd9:  u = '{OP_SUB, SRC_T2, SRC_PROD, DST_T2};
         4'd10: u = '{OP_MUL, SRC_DT, SRC_T0, DST_T0};
         4'd11: u = '{OP_ADD, SRC_X, SRC_PROD, DST_X};
         4'd12: u = '{OP_MUL, SRC_DT, SRC_T1, DST_T1};
         4'd13: u = '{OP_ADD, SRC_Y, SRC_PROD, DST_Y};
         4'd14: u = '{OP_MUL, SRC_DT, SRC_T2, DST_T2};
         4'd15: u = '{OP_ADD, SRC_Z, SRC_PROD, DST_Z};
         default: u = '{OP_ADD, SRC_ZERO, SRC_ZERO, DST_T0};
      endcase
      return u;
   endfunction

endpackage

// ===== src/lorenz_euler_integrator.sv =====
// lorenz system euler integrator with one shared multiply and saturating add unit
//
// Each request on req_ carries one tick; bit 0 of req_tdata is restart, which first
// reloads the point from start_x/y/z. The block answers every request with one
// item on rsp_: the point before the step in Q8.24 and a flag that is set when
// any intermediate or new coordinate of the step was clipped to the word range.
// The point then moves by one forward-euler step.
// Parameters sigma, beta, rho, the time step and the start point are written over
// the csr_ port at byte addresses 0, 4, ... 24 and can be read back.
// Timing: the step is run as 16 operations of one 32x32 multiplier and one
// saturating adder under a step counter, one operation a cycle. A request is
// taken only in the idle state; the run state works through the operations
// and the done state loads the result register. The result register lets a new
// request be taken while the last result waits; if the receiver still stalls
// when the next step is done, the block holds that result and takes no request
// until the slot frees.
// Reset restores the default parameters, puts the point at the start value and
// empties the result register.
module lorenz_euler_integrator (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [ler_pkg::REQ_DATA_W-1:0]  req_tdata,  // [0] restart, rest zero
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [31:0] point_x, [63:32] point_y, [95:64] point_z, [96] saturated, rest zero
   output logic [ler_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [ler_pkg::ADDR_W-1:0]      csr_paddr,
   input  logic [ler_pkg::WORD_W-1:0]      csr_pwdata,
   output logic [ler_pkg::WORD_W-1:0]      csr_prdata,
   output logic                            csr_pready
);
   import ler_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DONE
   } state_type;

   state_type state_ff;
   logic [STEP_W-1:0] step_ff;
   logic rsp_valid_ff;
   logic clip_ff;

   logic [WORD_W-1:0] sigma_ff, beta_ff, rho_ff;
   logic [DT_W-1:0] dt_ff;
   logic [WORD_W-1:0] start_x_ff, start_y_ff, start_z_ff;
   logic [WORD_W-1:0] pos_x_ff, pos_y_ff, pos_z_ff;

   logic [WORD_W-1:0] snap_x_ff, snap_y_ff, snap_z_ff;
   logic [WORD_W-1:0] t0_ff, t1_ff, t2_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;

   logic req_fire, csr_write, rsp_free;
   reg_idx_type csr_idx;
   uop_type uop;
   logic signed [WORD_W-1:0] op_a, op_b;
   logic [PROD_W-1:FRAC_W+WORD_W-1] prod_hi;
   logic prod_ov;
   logic [WORD_W-1:0] prod_val;
   logic [WORD_W:0] sum;
   logic sum_ov;
   logic [WORD_W-1:0] alu_val;
   logic uses_prod;
   logic clip_hit;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;
   assign rsp_free = !rsp_valid_ff || rsp_tready;
   assign csr_pready = 1'b1;
   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_idx = reg_idx_type'(csr_paddr[ADDR_W-1:2]);

   always_comb begin
      unique case (csr_idx)
         REG_SIGMA:     csr_prdata = sigma_ff;
         REG_BETA:      csr_prdata = beta_ff;
         REG_RHO:       csr_prdata = rho_ff;
         REG_TIME_STEP: csr_prdata = {1'b0, dt_ff};
         REG_START_X:   csr_prdata = start_x_ff;
         REG_START_Y:   csr_prdata = start_y_ff;
         REG_START_Z:   csr_prdata = start_z_ff;
         default:       csr_prdata = '0;
      endcase
   end

   // product back to word scale, clamped
   assign prod_hi = prod_ff[PROD_W-1:FRAC_W+WORD_W-1];
   assign prod_ov = !((&prod_hi) || !(|prod_hi));
   assign prod_val = prod_ov ? (prod_ff[PROD_W-1] ? WORD_MIN : WORD_MAX)
                             : prod_ff[FRAC_W+WORD_W-1:FRAC_W];

   function automatic logic [WORD_W-1:0] pick(
      src_type s, logic [WORD_W-1:0] x, logic [WORD_W-1:0] y, logic [WORD_W-1:0] z,
      logic [WORD_W-1:0] sg, logic [WORD_W-1:0] bt, logic [WORD_W-1:0] rh,
      logic [DT_W-1:0] dt, logic [WORD_W-1:0] t0, logic [WORD_W-1:0] t1,
      logic [WORD_W-1:0] t2, logic [WORD_W-1:0] pr);
      logic [WORD_W-1:0] v;
      unique case (s)
         SRC_X:     v = x;
         SRC_Y:     v = y;
         SRC_Z:     v = z;
         SRC_SIGMA: v = sg;
         SRC_BETA:  v = bt;
         SRC_RHO:   v = rh;
         SRC_DT:    v = {1'b0, dt};
         SRC_T0:    v = t0;
         SRC_T1:    v = t1;
         SRC_T2:    v = t2;
         SRC_PROD:  v = pr;
         default:   v = '0;
      endcase
      return v;
   endfunction

   always_comb begin
      uop = uop_at(step_ff);
      op_a = pick(uop.src_a, pos_x_ff, pos_y_ff, pos_z_ff, sigma_ff, beta_ff, rho_ff,
                  dt_ff, t0_ff, t1_ff, t2_ff, prod_val);
      op_b = pick(uop.src_b, pos_x_ff, pos_y_ff, pos_z_ff, sigma_ff, beta_ff, rho_ff,
                  dt_ff, t0_ff, t1_ff, t2_ff, prod_val);
      if (uop.op == OP_SUB) begin
         sum = {op_a[WORD_W-1], op_a} - {op_b[WORD_W-1], op_b};
      end else begin
         sum = {op_a[WORD_W-1], op_a} + {op_b[WORD_W-1], op_b};
      end
      sum_ov = sum[WORD_W] != sum[WORD_W-1];
      alu_val = sum_ov ? (sum[WORD_W] ? WORD_MIN : WORD_MAX) : sum[WORD_W-1:0];
      uses_prod = (uop.src_a == SRC_PROD) || (uop.src_b == SRC_PROD);
      clip_hit = (uop.op != OP_MUL) && (sum_ov || (uses_prod && prod_ov));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff <= '0;
         rsp_valid_ff <= 1'b0;
         clip_ff <= 1'b0;
         sigma_ff <= SIGMA_RST;
         beta_ff <= BETA_RST;
         rho_ff <= RHO_RST;
         dt_ff <= DT_RST;
         start_x_ff <= START_RST;
         start_y_ff <= START_RST;
         start_z_ff <= START_RST;
         pos_x_ff <= START_RST;
         pos_y_ff <= START_RST;
         pos_z_ff <= START_RST;
      end else begin
         if (csr_write) begin
            unique case (csr_idx)
               REG_SIGMA:     sigma_ff <= csr_pwdata;
               REG_BETA:      beta_ff <= csr_pwdata;
               REG_RHO:       rho_ff <= csr_pwdata;
               REG_TIME_STEP: dt_ff <= csr_pwdata[DT_W-1:0];
               REG_START_X:   start_x_ff <= csr_pwdata;
               REG_START_Y:   start_y_ff <= csr_pwdata;
               REG_START_Z:   start_z_ff <= csr_pwdata;
               default:       ;
            endcase
         end
         if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_fire) begin
                  if (req_tdata[0]) begin
                     pos_x_ff <= start_x_ff;
                     pos_y_ff <= start_y_ff;
                     pos_z_ff <= start_z_ff;
                  end
                  clip_ff <= 1'b0;
                  step_ff <= '0;
                  state_ff <= ST_RUN;
               end
            end
            ST_RUN: begin
               if (clip_hit) begin
                  clip_ff <= 1'b1;
               end
               if (uop.op != OP_MUL) begin
                  unique case (uop.dst)
                     DST_X:   pos_x_ff <= alu_val;
                     DST_Y:   pos_y_ff <= alu_val;
                     DST_Z:   pos_z_ff <= alu_val;
                     default: ;
                  endcase
               end
               if (step_ff == STEP_W'(NUM_STEPS - 1)) begin
                  state_ff <= ST_DONE;
               end else begin
                  step_ff <= step_ff + 1'b1;
               end
            end
            ST_DONE: begin
               if (rsp_free) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // payload: snapshot, temporaries, product and result word
   always_ff @(posedge clock) begin
      if (req_fire) begin
         snap_x_ff <= req_tdata[0] ? start_x_ff : pos_x_ff;
         snap_y_ff <= req_tdata[0] ? start_y_ff : pos_y_ff;
         snap_z_ff <= req_tdata[0] ? start_z_ff : pos_z_ff;
      end
      if (state_ff == ST_RUN) begin
         if (uop.op == OP_MUL) begin
            prod_ff <= op_a * op_b;
         end else begin
            unique case (uop.dst)
               DST_T0:  t0_ff <= alu_val;
               DST_T1:  t1_ff <= alu_val;
               DST_T2:  t2_ff <= alu_val;
               default: ;
            endcase
         end
      end
      if (state_ff == ST_DONE && rsp_free) begin
         rsp_data_ff <= {{(RSP_DATA_W-3*WORD_W-1){1'b0}}, clip_ff,
                         snap_z_ff, snap_y_ff, snap_x_ff};
      end
   end

`ifndef SYNTHESIS
   a_no_back_to_back: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_tready)
      else $error("request taken while a step is still running");

   a_restart_snapshot: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_tdata[0]) |=> (snap_x_ff == $past(start_x_ff)) &&
                                    (snap_z_ff == $past(start_z_ff)))
      else $error("restart did not report the start point");

   a_done_loads_result: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && rsp_free) |=> rsp_valid_ff && req_tready)
      else $error("finished step did not reach the result register");
`endif

endmodule

// ===== tb/lorenz_euler_integrator_tb.sv =====
// self-checking testbench for the lorenz euler integrator: stream ticks, apb parameters
module lorenz_euler_integrator_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import ler_pkg::*;

   localparam int HOLD_CYCLES = 300;
   localparam int SETTLE_CYCLES = 40;
   localparam int TIMEOUT_NS = 500000;
   localparam longint WORD_HI = 64'sd2147483647;
   localparam longint WORD_LO = -64'sd2147483648;

   typedef struct {
      logic [REQ_DATA_W-1:0] data;
      int gap;
   } tick_item_type;

   typedef struct {
      logic [WORD_W-1:0] px;
      logic [WORD_W-1:0] py;
      logic [WORD_W-1:0] pz;
      logic clipped;
   } point_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;   // [0] restart, rest zero
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   // [31:0] point_x, [63:32] point_y, [95:64] point_z, [96] saturated, rest zero
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [ADDR_W-1:0] csr_paddr = '0;
   logic [WORD_W-1:0] csr_pwdata = '0;
   logic [WORD_W-1:0] csr_prdata;
   logic csr_pready;

   tick_item_type pending_ticks[$];
   point_result_type expected_points[$];
   int send_wait = 0;
   int recv_wait = 0;
   int hold_left = 0;
   logic hold_go = 1'b0;
   bit no_idle = 1'b0;
   int mismatch_count = 0;

   // parameter and point state of the integrator as the testbench sees it
   longint sigma_q, beta_q, rho_q, dt_q, start_x_q, start_y_q, start_z_q;
   longint pos_x_q, pos_y_q, pos_z_q;
   bit step_clipped;

   lorenz_euler_integrator dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #1 clock = ~clock;

   function automatic longint clamp_word(longint v);
      if (v > WORD_HI) begin
         step_clipped = 1'b1;
         return WORD_HI;
      end
      if (v < WORD_LO) begin
         step_clipped = 1'b1;
         return WORD_LO;
      end
      return v;
   endfunction

   function automatic longint q_add(longint a, longint b);
      return clamp_word(a + b);
   endfunction

   function automatic longint q_sub(longint a, longint b);
      return clamp_word(a - b);
   endfunction

   // operands are word sized, so the full product fits in 64 bits
   function automatic longint q_mul(longint a, longint b);
      longint p;
      p = a * b;
      return clamp_word(p >>> FRAC_W);
   endfunction

   function automatic void load_defaults();
      sigma_q = longint'($signed(SIGMA_RST));
      beta_q = longint'($signed(BETA_RST));
      rho_q = longint'($signed(RHO_RST));
      dt_q = longint'(DT_RST);
      start_x_q = longint'($signed(START_RST));
      start_y_q = start_x_q;
      start_z_q = start_x_q;
      pos_x_q = start_x_q;
      pos_y_q = start_y_q;
      pos_z_q = start_z_q;
   endfunction

   // emit the current point, then take one euler step from it
   function automatic void advance_point(logic [REQ_DATA_W-1:0] data);
      point_result_type r;
      longint x, y, z, dx, dy, dz;
      if (data[0]) begin
         pos_x_q = start_x_q;
         pos_y_q = start_y_q;
         pos_z_q = start_z_q;
      end
      x = pos_x_q;
      y = pos_y_q;
      z = pos_z_q;
      r.px = x[WORD_W-1:0];
      r.py = y[WORD_W-1:0];
      r.pz = z[WORD_W-1:0];
      step_clipped = 1'b0;
      dx = q_mul(sigma_q, q_sub(y, x));
      dy = q_sub(q_mul(x, q_sub(rho_q, z)), y);
      dz = q_sub(q_mul(x, y), q_mul(beta_q, z));
      pos_x_q = q_add(x, q_mul(dt_q, dx));
      pos_y_q = q_add(y, q_mul(dt_q, dy));
      pos_z_q = q_add(z, q_mul(dt_q, dz));
      r.clipped = step_clipped;
      expected_points.push_back(r);
   endfunction

   task automatic report_mismatch(string field, logic [WORD_W-1:0] want,
                                  logic [WORD_W-1:0] got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("mismatch on %s: expected %h, got %h", field, want, got);
   endtask

   always @(posedge clock) begin : tick_driver
      tick_item_type item;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata <= '0;
         send_wait <= 0;
      end else begin
         if (req_tvalid && req_tready)
            advance_point(req_tdata);
         if (!req_tvalid || req_tready) begin
            if (send_wait != 0) begin
               send_wait <= send_wait - 1;
               req_tvalid <= 1'b0;
            end else if (pending_ticks.size() != 0) begin
               item = pending_ticks.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= item.data;
               send_wait <= item.gap;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : point_monitor
      point_result_type want;
      int w;
      if (reset) begin
         rsp_tready <= 1'b0;
         recv_wait <= 0;
         hold_left <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_points.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("result with no request pending: %h", rsp_tdata);
            end else begin
               want = expected_points.pop_front();
               if (rsp_tdata[31:0] !== want.px)
                  report_mismatch("point_x", want.px, rsp_tdata[31:0]);
               if (rsp_tdata[63:32] !== want.py)
                  report_mismatch("point_y", want.py, rsp_tdata[63:32]);
               if (rsp_tdata[95:64] !== want.pz)
                  report_mismatch("point_z", want.pz, rsp_tdata[95:64]);
               if (rsp_tdata[96] !== want.clipped)
                  report_mismatch("saturated", {31'b0, want.clipped}, {31'b0, rsp_tdata[96]});
            end
         end
         // long hold-off so the block fills up and backs up its input
         if (hold_go) begin
            hold_left <= HOLD_CYCLES;
            rsp_tready <= 1'b0;
         end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            rsp_tready <= (hold_left == 1);
         end else if (rsp_tvalid && rsp_tready) begin
            w = no_idle ? 0 : $urandom_range(0, 3);
            recv_wait <= w;
            rsp_tready <= (w == 0);
         end else if (recv_wait != 0) begin
            recv_wait <= recv_wait - 1;
            rsp_tready <= (recv_wait == 1);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic write_register(input reg_idx_type idx, input logic [WORD_W-1:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (idx)
         REG_SIGMA:     sigma_q = longint'($signed(value));
         REG_BETA:      beta_q = longint'($signed(value));
         REG_RHO:       rho_q = longint'($signed(value));
         REG_TIME_STEP: dt_q = longint'(value[DT_W-1:0]);
         REG_START_X:   start_x_q = longint'($signed(value));
         REG_START_Y:   start_y_q = longint'($signed(value));
         REG_START_Z:   start_z_q = longint'($signed(value));
         default: ;
      endcase
   endtask

   task automatic write_all(input logic [WORD_W-1:0] s, b, r, dt, sx, sy, sz);
      write_register(REG_SIGMA, s);
      write_register(REG_BETA, b);
      write_register(REG_RHO, r);
      write_register(REG_TIME_STEP, dt);
      write_register(REG_START_X, sx);
      write_register(REG_START_Y, sy);
      write_register(REG_START_Z, sz);
   endtask

   function automatic logic [WORD_W-1:0] corner_word();
      case ($urandom_range(0, 5))
         0: return WORD_MAX;
         1: return WORD_MIN;
         2: return '0;
         3: return 32'd1;
         4: return '1;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [WORD_W-1:0] near(logic [WORD_W-1:0] base, int spread);
      return base + WORD_W'($urandom_range(0, 2 * spread)) - WORD_W'(spread);
   endfunction

   task automatic load_parameters(input int mode);
      case (mode)
         0: write_all(near(SIGMA_RST, 1 << 26), near(BETA_RST, 1 << 24),
                      near(RHO_RST, 1 << 27), WORD_W'($urandom_range(0, 1 << 20)),
                      near('0, 1 << 28), near('0, 1 << 28), near(RHO_RST, 1 << 28));
         1: write_all($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                      $urandom);
         default: write_all(corner_word(), corner_word(), corner_word(), corner_word(),
                            corner_word(), corner_word(), corner_word());
      endcase
   endtask

   task automatic push_tick(input logic [REQ_DATA_W-1:0] data);
      tick_item_type item;
      item.data = data;
      item.gap = no_idle ? 0 : $urandom_range(0, 3);
      pending_ticks.push_back(item);
   endtask

   // mostly long trajectories, restarted now and then, with stray upper bits
   task automatic queue_ticks(input int count);
      logic [REQ_DATA_W-1:0] data;
      for (int i = 0; i < count; i++) begin
         data = ($urandom_range(0, 7) == 0) ? REQ_DATA_W'($urandom) : '0;
         data[0] = (i == 0) || ($urandom_range(0, 19) == 0);
         push_tick(data);
      end
   endtask

   task automatic wait_idle();
      do @(posedge clock);
      while (pending_ticks.size() != 0 || req_tvalid || send_wait != 0 ||
             expected_points.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      load_defaults();
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // defaults, restart, and upper request bits that must be ignored
      push_tick(8'h00);
      push_tick(8'h00);
      push_tick(8'h01);
      push_tick(8'h00);
      push_tick(8'hfe);
      push_tick(8'hff);
      push_tick(8'h00);
      wait_idle();

      write_all(WORD_MAX, WORD_MIN, WORD_MAX, 32'h7fffffff, WORD_MAX, WORD_MIN, WORD_MIN);
      push_tick(8'h01);
      push_tick(8'h00);
      push_tick(8'h00);
      wait_idle();

      write_all('0, '0, '0, '0, '0, '0, '0);
      push_tick(8'h01);
      push_tick(8'h00);
      wait_idle();

      // time step write with bit 31 set: only the low 31 bits count
      write_all(WORD_MIN, WORD_MAX, WORD_MIN, 32'hffffffff, WORD_MAX, WORD_MAX, WORD_MAX);
      push_tick(8'h01);
      push_tick(8'h00);
      push_tick(8'h00);
      wait_idle();

      write_all(SIGMA_RST, BETA_RST, RHO_RST, {1'b0, DT_RST}, START_RST, START_RST,
                START_RST);
      write_register(REG_NONE, $urandom);
      push_tick(8'h01);
      push_tick(8'h00);
      wait_idle();

      for (int ph = 0; ph < 8; ph++) begin
         load_parameters((ph < 3) ? 0 : ph % 3);
         no_idle = (ph == 2);
         queue_ticks(105);
         if (ph == 4) begin
            @(posedge clock);
            hold_go <= 1'b1;
            @(posedge clock);
            hold_go <= 1'b0;
         end
         wait_idle();
      end

      if (mismatch_count == 0 && expected_points.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("Verification failed");
      $finish;
   end

endmodule

// ===== files.f =====
src/ler_pkg.sv
src/lorenz_euler_integrator.sv
tb/lorenz_euler_integrator_tb.sv
